// ===== hw/rtl/pls_pkg.sv =====
// Types and constants shared by the positional list store.
package pls_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LEN_W   = 5;

    // Request codes; code 7 is unused and answers with the current length.
    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_DRAIN,
        S_INSW,
        S_RESP,
        S_DREAD,
        S_DEMIT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] entry_value;
        logic [LEN_W-1:0]          length;
        logic                      last;
    } out_t;

endpackage

// ===== hw/rtl/positional_list_store.sv =====
// Positional list store: ordered entry memory with shift-based insert and delete.
//
// Usage: one request per input transaction on s_valid/s_ready/s_data (op, value,
// position). Inserts and deletes give one result transaction; dump gives one
// result per stored entry, first to last, with last set on the final one (an
// empty dump gives a single EMPTY result). Results leave on m_valid/m_ready/
// m_data through an output register.
// Timing: an insert or delete shifts the entries behind its position one at a
// time, reading one and writing the one read before, then writes the last one
// read; an insert then writes its own entry. Only then is the result loaded. The
// cost is set by the single entry memory: one read and one write per cycle, so one
// entry moves per cycle. Dump reads each entry through the registered read port,
// then emits it, and waits while the output stalls. s_ready is high
// only while the sequencer is idle, so one request is in work at a time.
// Reset: aresetn (synchronous, active low) empties the store and the output
// register; the memory contents are not cleared and are never read unwritten.
// Stall: while m_ready is low a pending result holds, and the sequencer waits
// before loading the next one; nothing is lost.
module positional_list_store #(
    parameter int unsigned DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pls_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pls_pkg::out_t m_data
);
    import pls_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Entry memory: one write port, one registered read port.
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;
    logic [AW-1:0]             mem_wa;
    logic signed [VALUE_W-1:0] mem_wd;

    state_t state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             w_reg, w_next;
    logic [AW-1:0]             end_reg, end_next;
    logic [AW-1:0]             d_reg, d_next;
    logic                      pend_reg, pend_next;
    logic [AW-1:0]             pend_addr_reg, pend_addr_next;
    logic                      out_valid_reg, out_valid_next;
    out_t                      out_reg, out_next;

    logic                      accept;
    logic                      out_free;
    logic                      is_ins, is_del, reg_ins, reg_del;
    logic                      pos_ok;
    logic [POS_W-1:0]          pos_m1;
    logic [AW-1:0]             dec_idx;
    logic [AW-1:0]             cnt_m1;
    logic                      move_dir_up;
    logic                      dump_last;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Request decode against the current length.
    assign is_ins  = (s_data.op == OP_INS_FIRST) || (s_data.op == OP_INS_LAST)
                  || (s_data.op == OP_INS_AT);
    assign is_del  = (s_data.op == OP_DEL_FIRST) || (s_data.op == OP_DEL_LAST)
                  || (s_data.op == OP_DEL_AT);
    assign reg_ins = (op_reg == OP_INS_FIRST) || (op_reg == OP_INS_LAST)
                  || (op_reg == OP_INS_AT);
    assign reg_del = (op_reg == OP_DEL_FIRST) || (op_reg == OP_DEL_LAST)
                  || (op_reg == OP_DEL_AT);
    assign pos_ok  = (s_data.position != '0)
                  && (s_data.position <= POS_W'(count_reg));
    assign pos_m1  = s_data.position - POS_W'(1);
    assign cnt_m1  = AW'(count_reg - CW'(1));
    assign move_dir_up = reg_del;
    assign dump_last   = (CW'(d_reg) == (count_reg - CW'(1)));

    always_comb begin
        dec_idx = '0;
        priority case (1'b1)
            s_data.op == OP_INS_LAST:  dec_idx = AW'(count_reg);
            s_data.op == OP_DEL_LAST:  dec_idx = cnt_m1;
            s_data.op == OP_INS_AT,
            s_data.op == OP_DEL_AT:    dec_idx = count_reg == '0 ? '0 : AW'(pos_m1);
            default:                   dec_idx = '0;
        endcase
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (is_ins) begin
                        if (count_reg == CW'(DEPTH)) begin
                            state_next = S_RESP;
                        end else if (count_reg != '0 && s_data.op == OP_INS_AT && !pos_ok) begin
                            state_next = S_RESP;
                        end else if (CW'(dec_idx) < count_reg) begin
                            state_next = S_MOVE;
                        end else begin
                            state_next = S_INSW;
                        end
                    end else if (is_del) begin
                        if (count_reg != '0 && !(s_data.op == OP_DEL_AT && !pos_ok)
                                && (CW'(dec_idx) + CW'(1) < count_reg)) begin
                            state_next = S_MOVE;
                        end else begin
                            state_next = S_RESP;
                        end
                    end else if (s_data.op == OP_DUMP && count_reg != '0) begin
                        state_next = S_DREAD;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_MOVE: begin
                if (w_reg == end_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = reg_ins ? S_INSW : S_RESP;
            S_INSW:  state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DREAD: state_next = S_DEMIT;
            S_DEMIT: begin
                if (out_free) begin
                    state_next = dump_last ? S_IDLE : S_DREAD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output control.
    always_comb begin
        count_next     = count_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        end_next       = end_reg;
        d_next         = d_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_wa         = pend_addr_reg;
        mem_wd         = rd_data_reg;
        rd_addr        = d_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_data.op;
                    value_next = s_data.value;
                    idx_next   = dec_idx;
                    d_next     = '0;
                    status_next = ST_OK;
                    if (is_ins) begin
                        if (count_reg == CW'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else if (count_reg != '0 && s_data.op == OP_INS_AT && !pos_ok) begin
                            status_next = ST_BADPOS;
                        end
                        w_next   = cnt_m1;
                        end_next = dec_idx;
                    end else if (is_del) begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (s_data.op == OP_DEL_AT && !pos_ok) begin
                            status_next = ST_BADPOS;
                        end
                        w_next   = dec_idx + AW'(1);
                        end_next = cnt_m1;
                    end else if (s_data.op == OP_DUMP && count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end
                end
            end
            S_MOVE: begin
                // Read one source entry; write the one read last cycle.
                rd_addr        = w_reg;
                mem_we         = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = move_dir_up ? w_reg - AW'(1) : w_reg + AW'(1);
                w_next         = move_dir_up ? w_reg + AW'(1) : w_reg - AW'(1);
            end
            S_DRAIN: begin
                mem_we = 1'b1;
            end
            S_INSW: begin
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = value_reg;
            end
            S_RESP: begin
                if (out_free) begin
                    if (status_reg == ST_OK && reg_ins) begin
                        count_next = count_reg + CW'(1);
                    end else if (status_reg == ST_OK && reg_del) begin
                        count_next = count_reg - CW'(1);
                    end
                    out_valid_next     = 1'b1;
                    out_next.status    = status_reg;
                    out_next.entry_value = '0;
                    out_next.length    = LEN_W'(count_next);
                    out_next.last      = 1'b1;
                end
            end
            S_DREAD: begin
                rd_addr = d_reg;
            end
            S_DEMIT: begin
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_next.status      = ST_OK;
                    out_next.entry_value = rd_data_reg;
                    out_next.length      = LEN_W'(count_reg);
                    out_next.last        = dump_last;
                    d_next               = d_reg + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        w_reg         <= w_next;
        end_reg       <= end_next;
        d_reg         <= d_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    // Entry memory ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the positional list store.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int unsigned STORE_DEPTH  = 16;
    localparam int unsigned RANDOM_ITEMS = 310;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Stimulus modes for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    // Pending requests and results still owed by the block
    in_t   pend_q[$];
    bit    hold_q[$];
    out_t  exp_q[$];

    // Shadow of the store used to predict results
    logic signed [VALUE_W-1:0] list_mem [STORE_DEPTH];
    int unsigned list_len = 0;

    // Entry count tracked while generating stimulus
    int unsigned gen_len = 0;
    int unsigned total_items = 0;

    bit          s_took = 1'b0;
    int unsigned sent_count = 0;
    int unsigned accepted = 0;
    int unsigned checked = 0;
    int unsigned fail_count = 0;
    int unsigned cycles = 0;
    int unsigned status_hits [4] = '{0, 0, 0, 0};

    positional_list_store #(.DEPTH(STORE_DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Build one expected result; length is taken after the request
    function automatic out_t make_result(status_t st, logic signed [VALUE_W-1:0] val,
                                         logic lst);
        out_t r;
        r             = '0;
        r.status      = st;
        r.entry_value = val;
        r.length      = list_len[LEN_W-1:0];
        r.last        = lst;
        return r;
    endfunction

    // Apply one accepted request to the shadow store and queue its results
    task automatic predict_request(input in_t req);
        status_t     st;
        int unsigned idx;
        int unsigned k;
        st = ST_OK;
        case (req.op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                if (list_len >= STORE_DEPTH) begin
                    st = ST_FULL;
                end else if (list_len == 0 || req.op != OP_INS_AT ||
                             (req.position >= 1 && req.position <= list_len)) begin
                    // empty store ignores the position
                    if (list_len == 0 || req.op == OP_INS_FIRST)
                        idx = 0;
                    else if (req.op == OP_INS_LAST)
                        idx = list_len;
                    else
                        idx = req.position - 1;
                    for (k = list_len; k > idx; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[idx] = req.value;
                    list_len++;
                end else begin
                    st = ST_BADPOS;
                end
                exp_q.push_back(make_result(st, '0, 1'b1));
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (req.op != OP_DEL_AT ||
                             (req.position >= 1 && req.position <= list_len)) begin
                    if (req.op == OP_DEL_FIRST)
                        idx = 0;
                    else if (req.op == OP_DEL_LAST)
                        idx = list_len - 1;
                    else
                        idx = req.position - 1;
                    for (k = idx; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end else begin
                    st = ST_BADPOS;
                end
                exp_q.push_back(make_result(st, '0, 1'b1));
            end
            OP_DUMP: begin
                if (list_len == 0) begin
                    exp_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end else begin
                    for (k = 0; k < list_len; k++)
                        exp_q.push_back(make_result(ST_OK, list_mem[k], k + 1 == list_len));
                end
            end
            default: begin
                // unused code: no change, reports current length
                exp_q.push_back(make_result(ST_OK, '0, 1'b1));
            end
        endcase
    endtask

    // Compare one result transaction against the oldest expectation
    task automatic check_result(input out_t got);
        out_t want;
        if (exp_q.size() == 0) begin
            $error("unexpected result: status %0d entry_value %0d length %0d last %0d",
                   got.status, got.entry_value, got.length, got.last);
            fail_count++;
            return;
        end
        want = exp_q.pop_front();
        checked++;
        status_hits[want.status]++;
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
            fail_count++;
        end
        if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    // Queue one request and track the entry count it leaves behind
    task automatic add_item(input logic [OP_W-1:0] code, input logic signed [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos, input bit hold);
        in_t req;
        req.op       = code;
        req.value    = val;
        req.position = pos;
        pend_q.push_back(req);
        hold_q.push_back(hold);
        total_items++;
        if (code == OP_INS_FIRST || code == OP_INS_LAST || code == OP_INS_AT) begin
            if (gen_len < STORE_DEPTH &&
                (gen_len == 0 || code != OP_INS_AT || (pos >= 1 && pos <= gen_len)))
                gen_len++;
        end else if (code == OP_DEL_FIRST || code == OP_DEL_LAST || code == OP_DEL_AT) begin
            if (gen_len > 0 && (code != OP_DEL_AT || (pos >= 1 && pos <= gen_len)))
                gen_len--;
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (gen_len > 0 && $urandom_range(99) < 85)
            return POS_W'($urandom_range(gen_len, 1));
        return POS_W'($urandom_range(255));
    endfunction

    // One random request shaped by the current mode
    task automatic add_random(input int mode, input bit hold);
        int unsigned r;
        int unsigned ins_cut;
        int unsigned del_cut;
        logic [OP_W-1:0] code;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin ins_cut = 80; del_cut = 90; end
            MODE_DRAIN: begin ins_cut = 8;  del_cut = 88; end
            default:    begin ins_cut = 42; del_cut = 84; end
        endcase
        if (r < ins_cut)
            code = OP_W'($urandom_range(OP_INS_AT, OP_INS_FIRST));
        else if (r < del_cut)
            code = OP_W'($urandom_range(OP_DEL_AT, OP_DEL_FIRST));
        else if (r < 97)
            code = OP_DUMP;
        else
            code = OP_UNUSED;
        add_item(code, pick_value(), pick_position(), hold);
    endtask

    // Request driver: inputs change on the falling edge
    always @(negedge aclk) begin
        int unsigned idle_pct;
        int unsigned stall_pct;
        s_took <= 1'b0;
        if (sent_count < total_items / 3) begin
            idle_pct = 10; stall_pct = 49;
        end else if (sent_count < 2 * total_items / 3) begin
            idle_pct = 49; stall_pct = 10;
        end else begin
            idle_pct = 0; stall_pct = 0;
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
        if (!s_valid || s_took) begin
            if (!aresetn || pend_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (hold_q[0] && exp_q.size() != 0) begin
                // hold off until the block has answered everything
                s_valid <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data  <= pend_q.pop_front();
                void'(hold_q.pop_front());
                sent_count++;
            end
        end
    end

    // Monitor: sample both channels on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (s_valid && s_ready) begin
                predict_request(s_data);
                s_took <= 1'b1;
                accepted++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, exp_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned rand_made;
        int unsigned step;
        int          mode;
        int unsigned extra;

        // Directed: empty store, unused code, single entry, position limits
        add_item(OP_DUMP,      '0, 8'd0, 1'b0);
        add_item(OP_DEL_FIRST, '0, 8'd0, 1'b0);
        add_item(OP_DEL_LAST,  '0, 8'd0, 1'b0);
        add_item(OP_DEL_AT,    '0, 8'd0, 1'b0);
        add_item(OP_UNUSED,    '0, 8'd0, 1'b0);
        add_item(OP_INS_AT,    32'sh7FFF_FFFF, 8'd200, 1'b0);
        add_item(OP_DEL_AT,    '0, 8'd1, 1'b0);
        add_item(OP_INS_LAST,  32'sh8000_0000, 8'd0, 1'b0);
        add_item(OP_INS_FIRST, '0, 8'd0, 1'b0);
        add_item(OP_INS_AT,    -32'sd1, 8'd1, 1'b0);
        add_item(OP_INS_AT,    32'sh5A5A_A5A5, 8'd3, 1'b0);
        add_item(OP_INS_AT,    32'sh1234_5678, 8'd0, 1'b0);
        add_item(OP_INS_AT,    32'sh1234_5678, 8'd5, 1'b0);
        add_item(OP_INS_AT,    32'sh1234_5678, 8'd255, 1'b0);
        add_item(OP_DUMP,      '0, 8'd0, 1'b0);
        add_item(OP_DEL_AT,    '0, 8'd0, 1'b0);
        add_item(OP_DEL_AT,    '0, 8'd255, 1'b0);
        add_item(OP_DEL_AT,    '0, 8'd4, 1'b0);
        add_item(OP_DEL_FIRST, '0, 8'd0, 1'b0);
        add_item(OP_DEL_LAST,  '0, 8'd0, 1'b0);
        add_item(OP_UNUSED,    '0, 8'd0, 1'b0);
        add_item(OP_DUMP,      '0, 8'd0, 1'b0);

        // Random: fill to full, drain to empty, mixed stretches in between
        rand_made = 0;
        step = 0;
        while (rand_made < RANDOM_ITEMS) begin
            case (step % 4)
                0:       mode = MODE_FILL;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            extra = 0;
            while (rand_made < RANDOM_ITEMS) begin
                add_random(mode, rand_made == 0 || rand_made == RANDOM_ITEMS / 2);
                rand_made++;
                if (mode == MODE_FILL && gen_len == STORE_DEPTH)
                    extra++;
                else if (mode == MODE_DRAIN && gen_len == 0)
                    extra++;
                else if (mode == MODE_MIXED)
                    extra++;
                if ((mode == MODE_MIXED && extra >= 20) || (mode != MODE_MIXED && extra >= 4))
                    break;
            end
            step++;
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0 || s_valid || exp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (exp_q.size() != 0) begin
            $error("%0d expected results never arrived", exp_q.size());
            fail_count++;
        end

        $display("Ran %0d requests through fill, drain and mixed phases; %0d results checked",
                 accepted, checked);
        $display("Statuses seen: ok %0d, empty %0d, full %0d, bad position %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
                 status_hits[ST_BADPOS]);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pls_pkg.sv
hw/rtl/positional_list_store.sv
tb/testbench.sv
